// File: rtl/bcfd_pkg.sv
// Types and constants shared by the binary command frame decoder.
package bcfd_pkg;

	// Decoder phase
	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_HVAL = 3'd1,
		PH_HSTR = 3'd2,
		PH_TAG  = 3'd3,
		PH_PVAL = 3'd4,
		PH_PSTR = 3'd5,
		PH_CRC  = 3'd6,
		PH_SKIP = 3'd7
	} phase_t;

	// Result kinds
	typedef enum logic [2:0] {
		K_HEADER = 3'd0,
		K_PARAM  = 3'd1,
		K_SBYTE  = 3'd2,
		K_SEND   = 3'd3,
		K_OK     = 3'd4,
		K_PERR   = 3'd5,
		K_CERR   = 3'd6
	} kind_t;

	// Size codes held in the type size map
	localparam logic [2:0] SZ_STRING = 3'd4;

	localparam logic [23:0] MAP_RESET   = 24'h8D3440;
	localparam logic [7:0]  CRC_POLY    = 8'h07;
	localparam logic [4:0]  LETTER_MAX  = 5'd26;
	localparam logic [7:0]  BYTE_NUL    = 8'h00;
	localparam logic [7:0]  BYTE_CR     = 8'h0D;
	localparam logic [7:0]  BYTE_LF     = 8'h0A;
	localparam logic [7:0]  COUNT_MAX   = 8'hFF;

	// One result item
	typedef struct packed {
		kind_t       kind;
		logic [4:0]  letter;
		logic [2:0]  type_code;
		logic [63:0] value;
		logic [7:0]  param_count;
	} result_t;

endpackage

// File: rtl/bcfd_if.sv
// Valid/ready channels for input bytes and result items.
interface bcfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface bcfd_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [4:0]  letter;
	logic [2:0]  type_code;
	logic [63:0] value;
	logic [7:0]  param_count;

	modport source (output valid, output kind, output letter, output type_code,
		output value, output param_count, input ready);
	modport sink   (input valid, input kind, input letter, input type_code,
		input value, input param_count, output ready);
endinterface

// File: rtl/binary_command_frame_decoder.sv
// Top level of the binary command frame decoder.
//
// Takes one stream byte per item and gives at most one result item per byte:
// header, parameter, string byte, string end, frame ok, parse error or CRC
// error. Each accepted byte is decoded in the same cycle against the parser
// state, and its result lands in the output register, visible in the cycle after
// the byte is accepted. Throughput is one byte per cycle; the output register
// is the only stall point, and a new byte is taken whenever that register is
// empty or being drained in the same cycle. The type size map is written
// through cfg_wr_en/cfg_wr_data and should only change while no frame is open.
module binary_command_frame_decoder
	import bcfd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [23:0]   cfg_wr_data,
	bcfd_byte_if.sink     bytes,
	bcfd_res_if.source    results
);

	logic [23:0] map_q;
	logic        accept;
	logic        core_valid;
	result_t     core_res;
	logic        res_valid_q;
	result_t     res_q;

	// Hold the type size map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= MAP_RESET;
		end else if (cfg_wr_en) begin
			map_q <= cfg_wr_data;
		end
	end

	// Take a byte whenever the output register is free or draining
	assign bytes.ready = !res_valid_q || results.ready;
	assign accept      = bytes.valid && bytes.ready;

	bcfd_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (accept),
		.data_byte     (bytes.data_byte),
		.type_size_map (map_q),
		.res_valid     (core_valid),
		.res           (core_res)
	);

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= core_valid;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (accept && core_valid) begin
			res_q <= core_res;
		end
	end

	assign results.valid       = res_valid_q;
	assign results.kind        = res_q.kind;
	assign results.letter      = res_q.letter;
	assign results.type_code   = res_q.type_code;
	assign results.value       = res_q.value;
	assign results.param_count = res_q.param_count;

endmodule

// File: rtl/bcfd_crc8.sv
// One byte step of the CRC-8 (poly 0x07, MSB first).
module bcfd_crc8
	import bcfd_pkg::*;
(
	input  logic [7:0] crc_in,
	input  logic [7:0] data_in,
	output logic [7:0] crc_out
);

	// Shift the byte through the polynomial, one bit per step
	always_comb begin
		logic [7:0] v;
		v = crc_in ^ data_in;
		for (int i = 0; i < 8; i++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		crc_out = v;
	end

endmodule

// File: rtl/bcfd_core.sv
// Frame parser state and per-byte next-state and result logic.
module bcfd_core
	import bcfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic [23:0] type_size_map,
	output logic        res_valid,
	output result_t     res
);

	phase_t      phase_q, phase_d;
	logic [7:0]  crc_q, crc_d;
	logic [63:0] shift_q, shift_d;
	logic [3:0]  left_q, left_d;
	logic [4:0]  letter_q, letter_d;
	logic [2:0]  type_q, type_d;
	logic [7:0]  count_q, count_d;
	logic [2:0]  pos_q, pos_d;

	logic [7:0]  crc_seed;
	logic [7:0]  crc_next;
	logic [4:0]  b_letter;
	logic [2:0]  b_type;
	logic [2:0]  b_code;
	logic        b_bad;
	logic        b_zero;
	logic [3:0]  left_dec;
	logic [7:0]  count_inc;
	logic [63:0] shift_or;

	// Decode the byte as a tag
	assign b_letter = data_byte[4:0];
	assign b_type   = data_byte[7:5];
	assign b_code   = type_size_map[3 * b_type +: 3];
	assign b_bad    = (b_letter == 5'd0) || (b_letter > LETTER_MAX) || (b_code > SZ_STRING);
	assign b_zero   = (data_byte == BYTE_NUL);

	assign left_dec  = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;
	assign count_inc = (count_q != COUNT_MAX) ? count_q + 8'd1 : count_q;
	assign shift_or  = shift_q | ({56'd0, data_byte} << {pos_q, 3'b000});

	// Fold the byte into the running CRC
	assign crc_seed = (phase_q == PH_IDLE) ? 8'd0 : crc_q;
	bcfd_crc8 u_crc (
		.crc_in  (crc_seed),
		.data_in (data_byte),
		.crc_out (crc_next)
	);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE, PH_TAG: begin
				if (phase_q == PH_TAG && b_zero) begin
					phase_d = PH_CRC;
				end else if (phase_q == PH_TAG || data_byte[7]) begin
					if (b_bad) begin
						phase_d = PH_SKIP;
					end else if (b_code == SZ_STRING) begin
						phase_d = (phase_q == PH_IDLE) ? PH_HSTR : PH_PSTR;
					end else begin
						phase_d = (phase_q == PH_IDLE) ? PH_HVAL : PH_PVAL;
					end
				end
			end
			PH_HVAL, PH_PVAL: begin
				if (left_dec == 4'd0) phase_d = PH_TAG;
			end
			PH_HSTR, PH_PSTR: begin
				if (b_zero) phase_d = PH_TAG;
			end
			PH_CRC: phase_d = PH_IDLE;
			PH_SKIP: begin
				if (left_q != 4'd0) begin
					phase_d = PH_IDLE;
				end else if (!b_zero && (data_byte == BYTE_CR || data_byte == BYTE_LF)) begin
					phase_d = PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// Datapath updates and result
	always_comb begin
		crc_d     = crc_q;
		shift_d   = shift_q;
		left_d    = left_q;
		letter_d  = letter_q;
		type_d    = type_q;
		count_d   = count_q;
		pos_d     = pos_q;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_q)
			PH_IDLE, PH_TAG: begin
				if ((phase_q == PH_IDLE && data_byte[7]) || (phase_q == PH_TAG && !b_zero)) begin
					crc_d    = crc_next;
					letter_d = b_letter;
					type_d   = b_type;
					if (phase_q == PH_IDLE) count_d = 8'd0;
					res.letter      = b_letter;
					res.type_code   = b_type;
					res.param_count = (phase_q == PH_IDLE) ? 8'd0 : count_q;
					if (b_bad) begin
						left_d    = 4'd0;
						res_valid = 1'b1;
						res.kind  = K_PERR;
					end else if (b_code == SZ_STRING) begin
						res_valid = 1'b1;
						res.kind  = (phase_q == PH_IDLE) ? K_HEADER : K_PARAM;
					end else begin
						left_d  = 4'd1 << b_code[1:0];
						shift_d = 64'd0;
						pos_d   = 3'd0;
					end
				end
			end
			PH_HVAL, PH_PVAL: begin
				crc_d   = crc_next;
				shift_d = shift_or;
				pos_d   = pos_q + 3'd1;
				left_d  = left_dec;
				if (left_dec == 4'd0) begin
					if (phase_q == PH_PVAL) count_d = count_inc;
					res_valid       = 1'b1;
					res.kind        = (phase_q == PH_HVAL) ? K_HEADER : K_PARAM;
					res.letter      = letter_q;
					res.type_code   = type_q;
					res.value       = shift_or;
					res.param_count = (phase_q == PH_PVAL) ? count_inc : count_q;
				end
			end
			PH_HSTR, PH_PSTR: begin
				crc_d           = crc_next;
				res_valid       = 1'b1;
				res.letter      = letter_q;
				res.type_code   = type_q;
				res.param_count = count_q;
				if (!b_zero) begin
					res.kind  = K_SBYTE;
					res.value = {56'd0, data_byte};
				end else begin
					res.kind = K_SEND;
					if (phase_q == PH_PSTR) begin
						count_d         = count_inc;
						res.param_count = count_inc;
					end
				end
			end
			PH_CRC: begin
				res_valid       = 1'b1;
				res.kind        = (data_byte == crc_q) ? K_OK : K_CERR;
				res.param_count = count_q;
			end
			PH_SKIP: begin
				if (left_q != 4'd0) begin
					left_d = 4'd0;
				end else if (b_zero) begin
					left_d = 4'd1;
				end
			end
			default: ;
		endcase
	end

	// Advance state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			crc_q    <= 8'd0;
			shift_q  <= 64'd0;
			left_q   <= 4'd0;
			letter_q <= 5'd0;
			type_q   <= 3'd0;
			count_q  <= 8'd0;
			pos_q    <= 3'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			crc_q    <= crc_d;
			shift_q  <= shift_d;
			left_q   <= left_d;
			letter_q <= letter_d;
			type_q   <= type_d;
			count_q  <= count_d;
			pos_q    <= pos_d;
		end
	end

endmodule
